[rtl/imheq_pkg.sv]
// ----------------------------------------------------------------------------
// imheq_pkg
// Shared types and constants for the indexed min-heap event queue.
// ----------------------------------------------------------------------------
package imheq_pkg;

  localparam int NUM_IDS       = 64;
  localparam int ID_BITS       = 6;
  localparam int CNT_BITS      = 7;
  localparam int TIME_BITS     = 32;
  localparam int PARTICLE_BITS = 10;
  localparam logic [CNT_BITS-1:0] MAX_HELD = 7'd64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_REKEY  = 2'd2,
    OP_PURGE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_HERE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_DEL_RD, S_DEL_LD, S_DEL_T,
    S_SW_START, S_SW_PID, S_SW_PT, S_SW_DEC,
    S_SK_START, S_SK_LID, S_SK_LT, S_SK_RT, S_SK_SEL, S_SK_CMP, S_SK_DEC,
    S_PLACE,
    S_PG_RD, S_PG_ID, S_PG_CHK,
    S_SUM1, S_SUM2, S_EMIT
  } state_t;

endpackage

[rtl/imheq_cmp.sv]
// ----------------------------------------------------------------------------
// imheq_cmp
// Shared time comparator: registered strict less-than of two keys.
// ----------------------------------------------------------------------------
module imheq_cmp (
  input  logic                           clk,
  input  logic [imheq_pkg::TIME_BITS-1:0] a,
  input  logic [imheq_pkg::TIME_BITS-1:0] b,
  output logic                           lt_r
);
  import imheq_pkg::*;

  always_ff @(posedge clk) begin
    lt_r <= (a < b);
  end

endmodule

[rtl/indexed_min_heap_event_queue.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap_event_queue
// Indexed binary min-heap of events keyed by time, with id-to-slot map.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_tready is low while an operation runs, and
// the next item can be taken in the same cycle as the result item appears.
// All sift steps share one registered time comparator and tables with one
// read port each. A refused insert or an absent id goes straight to the
// result, and a delete of the last slot moves nothing. An insert, rekey or
// delete decodes the item (a delete also fetches the last slot's entry), then
// the event swims up a level at a time until a compare stops it or it reaches
// the root; when it did not swim it sinks, comparing two children or only a
// left one at each level, until a compare stops it or there is no child. The
// event is then placed and the result built. A particle purge scans the
// occupied slots, runs a delete sift for each match and repeats until a pass
// removes nothing. The result is held in an output register, so a waiting
// result does not block taking the next item; only its result waits.
module indexed_min_heap_event_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[1:0], event_id[7:2], time_key[39:8], first_particle[49:40],
  // second_particle[59:50], has_second[60], zero fill[63:61]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], count[8:2], min_valid[9], min_event[15:10], min_time[47:16],
  // second_valid[48], second_event[54:49], removed[61:55], zero fill[63:62]
  output logic [63:0] out_tdata
);
  import imheq_pkg::*;

  logic [ID_BITS-1:0]       heap_m  [NUM_IDS];   // slot-1 indexed
  logic [ID_BITS-1:0]       pos_m   [NUM_IDS];   // slot-1 per id
  logic [TIME_BITS-1:0]     time_m  [NUM_IDS];
  logic [PARTICLE_BITS-1:0] p1_m    [NUM_IDS];
  logic [PARTICLE_BITS-1:0] p2_m    [NUM_IDS];
  logic                     pair_m  [NUM_IDS];
  logic [NUM_IDS-1:0]       present_r, present_nxt;

  state_t state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt, rem_r, rem_nxt;
  logic [CNT_BITS-1:0] k_r, k_nxt, j_r, j_nxt, i_r, i_nxt;   // 1-based slots
  op_t op_r, op_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic [PARTICLE_BITS-1:0] a_r, a_nxt, b_r, b_nxt;
  logic pr_r, pr_nxt, hit_r, hit_nxt, moved_r, moved_nxt;
  status_t st_r, st_nxt;
  // moving entry of the sift and the candidate parent or child
  logic [ID_BITS-1:0] eid_r, eid_nxt, cid_r, cid_nxt, rid_r, rid_nxt;
  logic [TIME_BITS-1:0] et_r, et_nxt, ct_r, ct_nxt;
  logic out_v_r, out_v_nxt;
  logic [63:0] out_d_r, out_d_nxt;
  logic [ID_BITS-1:0] min_id_r, min_id_nxt;

  // table port controls
  logic hw_en;  logic [ID_BITS-1:0] hw_a, hw_d;
  logic pw_en;  logic [ID_BITS-1:0] pw_a, pw_d;
  logic ew_en;  logic ew_full;
  logic [ID_BITS-1:0] hr_a, tr_a, ps_a, er_a;
  logic [ID_BITS-1:0] hr_q;
  logic [TIME_BITS-1:0] tr_q;
  logic [ID_BITS-1:0] pos_q;
  logic [PARTICLE_BITS-1:0] p1_q, p2_q;
  logic pair_q;

  logic [TIME_BITS-1:0] ca, cb;
  logic lt_r;

  // child slots of k, one bit wider than a slot
  logic [CNT_BITS:0] lc_w, rc_w;

  imheq_cmp u_cmp (.clk(clk), .a(ca), .b(cb), .lt_r(lt_r));

  assign lc_w = {k_r, 1'b0};
  assign rc_w = {k_r, 1'b1};

  always_ff @(posedge clk) begin
    if (hw_en) heap_m[hw_a] <= hw_d;
    if (pw_en) pos_m[pw_a] <= pw_d;
    if (ew_en) begin
      time_m[id_r] <= t_r;
      if (ew_full) begin
        p1_m[id_r]   <= a_r;
        p2_m[id_r]   <= b_r;
        pair_m[id_r] <= pr_r;
      end
    end
    hr_q   <= heap_m[hr_a];
    tr_q   <= time_m[tr_a];
    pos_q  <= pos_m[ps_a];
    p1_q   <= p1_m[er_a];
    p2_q   <= p2_m[er_a];
    pair_q <= pair_m[er_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; present_r <= '0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; present_r <= present_nxt;
      out_v_r <= out_v_nxt;
    end
    rem_r <= rem_nxt; k_r <= k_nxt; j_r <= j_nxt; i_r <= i_nxt; op_r <= op_nxt;
    id_r <= id_nxt; t_r <= t_nxt; a_r <= a_nxt; b_r <= b_nxt; pr_r <= pr_nxt;
    hit_r <= hit_nxt; moved_r <= moved_nxt; st_r <= st_nxt;
    eid_r <= eid_nxt; cid_r <= cid_nxt; rid_r <= rid_nxt;
    et_r <= et_nxt; ct_r <= ct_nxt; out_d_r <= out_d_nxt; min_id_r <= min_id_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  function automatic logic [ID_BITS-1:0] sl(input logic [CNT_BITS-1:0] s);
    logic [CNT_BITS-1:0] m;
    m = s - 7'd1;
    return m[ID_BITS-1:0];
  endfunction

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; present_nxt = present_r; rem_nxt = rem_r;
    k_nxt = k_r; j_nxt = j_r; i_nxt = i_r; op_nxt = op_r; id_nxt = id_r;
    t_nxt = t_r; a_nxt = a_r; b_nxt = b_r; pr_nxt = pr_r; hit_nxt = hit_r;
    moved_nxt = moved_r; st_nxt = st_r;
    eid_nxt = eid_r; cid_nxt = cid_r; rid_nxt = rid_r; et_nxt = et_r; ct_nxt = ct_r;
    out_v_nxt = out_v_r; out_d_nxt = out_d_r; min_id_nxt = min_id_r;
    hw_en = 1'b0; hw_a = '0; hw_d = '0; pw_en = 1'b0; pw_a = '0; pw_d = '0;
    ew_en = 1'b0; ew_full = 1'b0;
    hr_a = '0; tr_a = '0; er_a = id_r; ps_a = in_tdata[7:2];
    ca = et_r; cb = ct_r;
    if (out_v_r && out_tready) out_v_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt = op_t'(in_tdata[1:0]); id_nxt = in_tdata[7:2];
          t_nxt = in_tdata[39:8]; a_nxt = in_tdata[49:40]; b_nxt = in_tdata[59:50];
          pr_nxt = in_tdata[60];
          st_nxt = ST_OK; rem_nxt = '0; hit_nxt = 1'b0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        // pos_q holds slot-1 of id_r
        eid_nxt = id_r; et_nxt = t_r; moved_nxt = 1'b0;
        k_nxt = {1'b0, pos_q} + 7'd1;
        unique case (op_r)
          OP_INSERT: begin
            if (present_r[id_r]) begin
              ew_en = 1'b1; ew_full = 1'b1; state_nxt = S_SW_START;
            end else if (cnt_r >= MAX_HELD) begin
              st_nxt = ST_FULL; state_nxt = S_SUM1;
            end else begin
              ew_en = 1'b1; ew_full = 1'b1;
              cnt_nxt = cnt_r + 7'd1; k_nxt = cnt_r + 7'd1;
              present_nxt[id_r] = 1'b1;
              state_nxt = S_SW_START;
            end
          end
          OP_DELETE: begin
            if (!present_r[id_r]) begin
              st_nxt = ST_NOT_HERE; state_nxt = S_SUM1;
            end else state_nxt = S_DEL_RD;
          end
          OP_REKEY: begin
            if (!present_r[id_r]) begin
              st_nxt = ST_NOT_HERE; state_nxt = S_SUM1;
            end else begin
              ew_en = 1'b1; state_nxt = S_SW_START;
            end
          end
          OP_PURGE: begin
            i_nxt = 7'd1; state_nxt = S_PG_RD;
          end
        endcase
      end
      S_DEL_RD: begin
        // fetch the entry of the last slot
        hr_a = sl(cnt_r);
        present_nxt[id_r] = 1'b0;
        rem_nxt = rem_r + 7'd1;
        state_nxt = S_DEL_LD;
      end
      S_DEL_LD: begin
        eid_nxt = hr_q; tr_a = hr_q; moved_nxt = 1'b0;
        cnt_nxt = cnt_r - 7'd1;
        // freed slot was the last one: nothing to move
        if (k_r == cnt_r) state_nxt = (op_r == OP_PURGE) ? S_PG_RD : S_SUM1;
        else state_nxt = S_DEL_T;
      end
      S_DEL_T: begin
        et_nxt = tr_q; state_nxt = S_SW_START;
      end
      S_SW_START: begin
        if (k_r > 7'd1) begin
          hr_a = sl({1'b0, k_r[CNT_BITS-1:1]});
          state_nxt = S_SW_PID;
        end else state_nxt = moved_r ? S_PLACE : S_SK_START;
      end
      S_SW_PID: begin
        cid_nxt = hr_q; tr_a = hr_q; state_nxt = S_SW_PT;
      end
      S_SW_PT: begin
        ca = et_r; cb = tr_q; state_nxt = S_SW_DEC;
      end
      S_SW_DEC: begin
        if (lt_r) begin
          // pull the parent down into the hole
          hw_en = 1'b1; hw_a = sl(k_r); hw_d = cid_r;
          pw_en = 1'b1; pw_a = cid_r; pw_d = sl(k_r);
          k_nxt = {1'b0, k_r[CNT_BITS-1:1]};
          moved_nxt = 1'b1;
          state_nxt = S_SW_START;
        end else state_nxt = moved_r ? S_PLACE : S_SK_START;
      end
      S_SK_START: begin
        if (lc_w <= {1'b0, cnt_r}) begin
          hr_a = sl(lc_w[CNT_BITS-1:0]); state_nxt = S_SK_LID;
        end else state_nxt = S_PLACE;
      end
      S_SK_LID: begin
        cid_nxt = hr_q; tr_a = hr_q; j_nxt = lc_w[CNT_BITS-1:0];
        if (rc_w <= {1'b0, cnt_r}) hr_a = sl(rc_w[CNT_BITS-1:0]);
        state_nxt = S_SK_LT;
      end
      S_SK_LT: begin
        ct_nxt = tr_q;
        if (rc_w <= {1'b0, cnt_r}) begin
          rid_nxt = hr_q; tr_a = hr_q; state_nxt = S_SK_RT;
        end else state_nxt = S_SK_CMP;
      end
      S_SK_RT: begin
        // test whether right is earlier than left; hold the right time for the next cycle
        ca = tr_q; cb = ct_r; tr_a = rid_r; state_nxt = S_SK_SEL;
      end
      S_SK_SEL: begin
        if (lt_r) begin
          cid_nxt = rid_r; ct_nxt = tr_q; j_nxt = rc_w[CNT_BITS-1:0];
        end
        state_nxt = S_SK_CMP;
      end
      S_SK_CMP: begin
        ca = ct_r; cb = et_r; state_nxt = S_SK_DEC;
      end
      S_SK_DEC: begin
        if (lt_r) begin
          // lift the child into the hole
          hw_en = 1'b1; hw_a = sl(k_r); hw_d = cid_r;
          pw_en = 1'b1; pw_a = cid_r; pw_d = sl(k_r);
          k_nxt = j_r; state_nxt = S_SK_START;
        end else state_nxt = S_PLACE;
      end
      S_PLACE: begin
        hw_en = 1'b1; hw_a = sl(k_r); hw_d = eid_r;
        pw_en = 1'b1; pw_a = eid_r; pw_d = sl(k_r);
        state_nxt = (op_r == OP_PURGE) ? S_PG_RD : S_SUM1;
      end
      S_PG_RD: begin
        if (i_r > cnt_r) begin
          // rescan while the last pass removed something
          if (hit_r) begin
            hit_nxt = 1'b0; i_nxt = 7'd1;
          end else state_nxt = S_SUM1;
        end else begin
          hr_a = sl(i_r); state_nxt = S_PG_ID;
        end
      end
      S_PG_ID: begin
        id_nxt = hr_q; er_a = hr_q; state_nxt = S_PG_CHK;
      end
      S_PG_CHK: begin
        if (p1_q == a_r || (pair_q && p2_q == a_r)) begin
          // remove and examine the same slot again
          hit_nxt = 1'b1; k_nxt = i_r; state_nxt = S_DEL_RD;
        end else begin
          i_nxt = i_r + 7'd1; state_nxt = S_PG_RD;
        end
      end
      S_SUM1: begin
        hr_a = '0; state_nxt = S_SUM2;
      end
      S_SUM2: begin
        tr_a = hr_q; min_id_nxt = hr_q; hr_a = 6'd1; state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold the reads until the output register is free
        tr_a = min_id_r; hr_a = 6'd1;
        if (!out_v_r || out_tready) begin
          out_d_nxt = '0;
          out_d_nxt[1:0]   = st_r;
          out_d_nxt[8:2]   = cnt_r;
          out_d_nxt[9]     = (cnt_r >= 7'd1);
          out_d_nxt[15:10] = (cnt_r >= 7'd1) ? min_id_r : '0;
          out_d_nxt[47:16] = (cnt_r >= 7'd1) ? tr_q : '0;
          out_d_nxt[48]    = (cnt_r >= 7'd2);
          out_d_nxt[54:49] = (cnt_r >= 7'd2) ? hr_q : '0;
          out_d_nxt[61:55] = rem_r;
          out_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

endmodule
